// ===== hdl/amf_pkg.sv =====
// Shared constants, types and the sine table builder for the alien-map pixel filter.
// Used by alien_map_pixel_filter. No dependencies.
`timescale 1ns / 1ps

package amf_pkg;

    // Quarter-wave table depth; the table holds SINE_DEPTH + 1 entries
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = $clog2(SINE_DEPTH + 1);
    localparam int SINE_W     = 17;
    localparam int P_W        = 31 + SINE_AW;

    // round(2^30 / (2*pi)) and pi/2 in Q30
    localparam logic [27:0] TURNS_K          = 28'd170891319;
    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
    localparam logic [30:0] ONE_Q30          = 31'h4000_0000;

    // Series denominators (n-1)*n for the odd terms x^3 .. x^15
    localparam longint unsigned TAYLOR_DEN_3  = 64'd6;
    localparam longint unsigned TAYLOR_DEN_5  = 64'd20;
    localparam longint unsigned TAYLOR_DEN_7  = 64'd42;
    localparam longint unsigned TAYLOR_DEN_9  = 64'd72;
    localparam longint unsigned TAYLOR_DEN_11 = 64'd110;
    localparam longint unsigned TAYLOR_DEN_13 = 64'd156;
    localparam longint unsigned TAYLOR_DEN_15 = 64'd210;

    // Configuration register indexes
    localparam logic [2:0] REG_FREQ_RED    = 3'd0;
    localparam logic [2:0] REG_FREQ_GREEN  = 3'd1;
    localparam logic [2:0] REG_FREQ_BLUE   = 3'd2;
    localparam logic [2:0] REG_PHASE_RED   = 3'd3;
    localparam logic [2:0] REG_PHASE_GREEN = 3'd4;
    localparam logic [2:0] REG_PHASE_BLUE  = 3'd5;
    localparam logic [2:0] REG_KEEP_MASK   = 3'd6;

    typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_DEPTH];

    // Odd Taylor series of sin up to x^15, Q30 in and out
    function automatic longint unsigned taylor_sin_q30(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        // Alternate subtract and add, starting with the cubic term
        term = ((term * x2) >> 30) / TAYLOR_DEN_3;
        sum  = sum - term;
        term = ((term * x2) >> 30) / TAYLOR_DEN_5;
        sum  = sum + term;
        term = ((term * x2) >> 30) / TAYLOR_DEN_7;
        sum  = sum - term;
        term = ((term * x2) >> 30) / TAYLOR_DEN_9;
        sum  = sum + term;
        term = ((term * x2) >> 30) / TAYLOR_DEN_11;
        sum  = sum - term;
        term = ((term * x2) >> 30) / TAYLOR_DEN_13;
        sum  = sum + term;
        term = ((term * x2) >> 30) / TAYLOR_DEN_15;
        sum  = sum - term;
        return sum;
    endfunction

    // Build the quarter-wave table, Q16 entries
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned x;
        longint unsigned e;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x      = (HALF_PI_Q30 * longint'(k)) / SINE_DEPTH;
            e      = (taylor_sin_q30(x) + 64'd8192) >> 14;
            rom[k] = e[SINE_W-1:0];
        end
        return rom;
    endfunction

endpackage

// ===== hdl/amf_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module amf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then read both ports into registers
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== hdl/alien_map_pixel_filter.sv =====
// Alien-map pixel filter top level: seven-stage pixel pipeline and config registers.
// Depends on amf_pkg and amf_ram.
`timescale 1ns / 1ps

// Usage:
//  Pixels enter on in_valid/in_ready with in_red/green/blue/alpha/last and leave on
//  out_valid/out_ready. Each colour channel becomes 0.5*(1+sin((2v-1)*freq+phase))
//  in Q0.16 unless its keep_mask bit is set; alpha and last pass through.
//  Registers are written on cfg_valid/cfg_ready (cfg_ready is always high) with
//  cfg_index 0..6 and cfg_data; index 7 is ignored. Write them only while idle.
//  The pipeline has seven register stages; out_valid is driven by the last of them.
//  Throughput is one pixel per cycle while out_ready stays high, since every stage
//  loads while its successor moves on (angle multiply, add, turns multiply, wrap,
//  table read, interpolation multiply, output).
//  After reset the three sine tables are loaded from the built-in table, one entry
//  per cycle, SINE_DEPTH + 1 = 1025 entries; in_ready stays low during the load.
//  Each stage holds its pixel while the next stage is full and held, so a stalled
//  receiver fills the pipeline first; in_ready drops only when all seven are full.
module alien_map_pixel_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] in_red,
    input  logic [15:0] in_green,
    input  logic [15:0] in_blue,
    input  logic [15:0] in_alpha,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_red,
    output logic [15:0] out_green,
    output logic [15:0] out_blue,
    output logic [15:0] out_alpha,
    output logic        out_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam amf_pkg::sine_rom_t SINE_ROM = amf_pkg::build_sine_rom();

    // Config registers
    logic signed [15:0] freq_reg  [3];
    logic signed [15:0] phase_reg [3];
    logic [2:0]         keep_reg;

    // Table load
    logic [amf_pkg::SINE_AW-1:0] fill_cnt_reg;
    logic                        fill_done_reg;
    logic                        ram_we;

    // Pipeline control
    logic [7:1] valid_reg;
    logic [8:1] rdy;
    logic [7:1] vin;
    logic [7:1] ld;

    // Pass-through payload
    logic [15:0] alpha_reg [1:7];
    logic        last_reg  [1:7];
    logic [15:0] pix_in    [3];
    logic [15:0] pix_out   [3];

    assign cfg_ready = 1'b1;

    // Config write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg[0]  <= 16'sd1024;
            freq_reg[1]  <= 16'sd0;
            freq_reg[2]  <= 16'sd0;
            phase_reg[0] <= 16'sd0;
            phase_reg[1] <= 16'sd0;
            phase_reg[2] <= 16'sd0;
            keep_reg     <= 3'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                amf_pkg::REG_FREQ_RED:    freq_reg[0]  <= cfg_data;
                amf_pkg::REG_FREQ_GREEN:  freq_reg[1]  <= cfg_data;
                amf_pkg::REG_FREQ_BLUE:   freq_reg[2]  <= cfg_data;
                amf_pkg::REG_PHASE_RED:   phase_reg[0] <= cfg_data;
                amf_pkg::REG_PHASE_GREEN: phase_reg[1] <= cfg_data;
                amf_pkg::REG_PHASE_BLUE:  phase_reg[2] <= cfg_data;
                amf_pkg::REG_KEEP_MASK:   keep_reg     <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Sweep the table into the RAMs after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg  <= '0;
            fill_done_reg <= 1'b0;
        end
        else if (!fill_done_reg)
        begin
            if (fill_cnt_reg == amf_pkg::SINE_AW'(amf_pkg::SINE_DEPTH))
                fill_done_reg <= 1'b1;
            else
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
        end
    end

    assign ram_we = !fill_done_reg;

    // Stage handshake: a stage loads when empty or when its successor moves
    always_comb
    begin
        rdy[8] = out_ready;
        for (int k = 7; k >= 1; k--)
            rdy[k] = !valid_reg[k] || rdy[k+1];
        vin[1] = in_valid && fill_done_reg;
        for (int k = 2; k <= 7; k++)
            vin[k] = valid_reg[k-1];
        for (int k = 1; k <= 7; k++)
            ld[k] = rdy[k] && vin[k];
    end

    assign in_ready = rdy[1] && fill_done_reg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= 7; k++)
                if (rdy[k])
                    valid_reg[k] <= vin[k];
        end
    end

    // Carry alpha and last alongside
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            alpha_reg[1] <= in_alpha;
            last_reg[1]  <= in_last;
        end
        for (int k = 2; k <= 7; k++)
            if (ld[k])
            begin
                alpha_reg[k] <= alpha_reg[k-1];
                last_reg[k]  <= last_reg[k-1];
            end
    end

    assign pix_in[0] = in_red;
    assign pix_in[1] = in_green;
    assign pix_in[2] = in_blue;

    // One lane per colour channel
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        logic [15:0]                 v_reg [1:6];
        logic [16:0]                 w1;
        logic signed [18:0]          s1;
        logic signed [34:0]          prod1_reg;
        logic signed [35:0]          a_reg;
        logic [45:0]                 pl_reg;
        logic signed [46:0]          ph_reg;
        logic [55:0]                 sum4;
        logic [31:0]                 t_reg;
        logic [30:0]                 r4;
        logic [amf_pkg::P_W-1:0]     p4;
        logic [amf_pkg::SINE_AW-1:0] ia4;
        logic [amf_pkg::SINE_AW-1:0] ib4;
        logic [29:0]                 f_reg;
        logic                        neg5_reg;
        logic [amf_pkg::SINE_W-1:0]  ta;
        logic [amf_pkg::SINE_W-1:0]  tb;
        logic [47:0]                 pa_reg;
        logic [47:0]                 pb_reg;
        logic                        neg6_reg;
        logic [48:0]                 acc7;
        logic [16:0]                 m7;
        logic signed [18:0]          mm7;
        logic signed [18:0]          y7;
        logic [15:0]                 res7;
        logic [15:0]                 out_reg;

        // Stage 1: signed Q1.16 and angle product
        assign w1 = {1'b0, pix_in[ch]} + 17'(pix_in[ch][15]);
        assign s1 = $signed({1'b0, w1, 1'b0}) - 19'sd65536;

        // Stage 4: wrap to turns
        assign sum4 = {ph_reg[37:0], 18'b0} + {10'b0, pl_reg};

        // Stage 5 address: fold quadrant, scale into the table
        always_comb
        begin
            r4 = {1'b0, t_reg[29:0]};
            if (t_reg[30])
                r4 = amf_pkg::ONE_Q30 - r4;
            p4  = amf_pkg::P_W'(r4) * amf_pkg::P_W'(amf_pkg::SINE_DEPTH);
            ia4 = p4[30 +: amf_pkg::SINE_AW];
            ib4 = (ia4 < amf_pkg::SINE_AW'(amf_pkg::SINE_DEPTH)) ?
                  ia4 + amf_pkg::SINE_AW'(1) : ia4;
        end

        amf_ram #(
            .WIDTH(amf_pkg::SINE_W),
            .DEPTH(amf_pkg::SINE_DEPTH + 1)
        ) u_sine_ram (
            .clk     (clk),
            .we      (ram_we),
            .waddr   (fill_cnt_reg),
            .wdata   (SINE_ROM[fill_cnt_reg]),
            .re      (ld[5]),
            .raddr_a (ia4),
            .raddr_b (ib4),
            .rdata_a (ta),
            .rdata_b (tb)
        );

        // Stage 7: round, sign, offset and saturate
        always_comb
        begin
            acc7 = 49'(pa_reg) + 49'(pb_reg) + 49'(1 << 29);
            m7   = acc7[46:30];
            mm7  = neg6_reg ? -$signed({2'b0, m7}) : $signed({2'b0, m7});
            y7   = 19'sd65537 + mm7;
            res7 = (y7[18:17] != 2'b00) ? 16'hFFFF : y7[16:1];
        end

        // Pipeline registers
        always_ff @(posedge clk)
        begin
            if (ld[1])
            begin
                v_reg[1]  <= pix_in[ch];
                prod1_reg <= s1 * freq_reg[ch];
            end
            if (ld[2])
            begin
                v_reg[2] <= v_reg[1];
                a_reg    <= {prod1_reg[34], prod1_reg}
                            + $signed({{6{phase_reg[ch][15]}}, phase_reg[ch], 14'b0});
            end
            if (ld[3])
            begin
                v_reg[3] <= v_reg[2];
                pl_reg   <= 46'(a_reg[17:0]) * 46'(amf_pkg::TURNS_K);
                ph_reg   <= $signed(a_reg[35:18]) * $signed({1'b0, amf_pkg::TURNS_K});
            end
            if (ld[4])
            begin
                v_reg[4] <= v_reg[3];
                t_reg    <= sum4[55:24];
            end
            if (ld[5])
            begin
                v_reg[5] <= v_reg[4];
                f_reg    <= p4[29:0];
                neg5_reg <= t_reg[31];
            end
            if (ld[6])
            begin
                v_reg[6] <= v_reg[5];
                pa_reg   <= 48'(ta) * 48'(amf_pkg::ONE_Q30 - {1'b0, f_reg});
                pb_reg   <= 48'(tb) * 48'(f_reg);
                neg6_reg <= neg5_reg;
            end
            if (ld[7])
            begin
                out_reg  <= keep_reg[ch] ? v_reg[6] : res7;
            end
        end

        assign pix_out[ch] = out_reg;
    end

    // Output stage: keep select is resolved on entry to stage 7
    assign out_valid = valid_reg[7];
    assign out_red   = pix_out[0];
    assign out_green = pix_out[1];
    assign out_blue  = pix_out[2];
    assign out_alpha = alpha_reg[7];
    assign out_last  = last_reg[7];

    // The table load finishes once and never restarts
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_done_reg |=> fill_done_reg)
        else $error("table load restarted");

    // No pixel enters while the tables are loading
    assert property (@(posedge clk) disable iff (!rst_n)
        !fill_done_reg |=> !valid_reg[1])
        else $error("pixel accepted during table load");

    // A stalled output keeps the pixel queued behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[6] && valid_reg[7] && !out_ready) |=> (valid_reg[6] && valid_reg[7]))
        else $error("pixel lost under stall");

endmodule
